// ===== rtl/core/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and constants for the rotated array search
// Field widths, action codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int INDEX_W = 10;
  localparam int LEN_W   = 11;
  localparam int POS_W   = 10;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_W0,
    S_PCMP,
    S_PVAL,
    S_LVAL,
    S_BCMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsa_in_if.sv =====
// ----------------------------------------------------------------------------
// rsa_in_if: input word channel
// Carries load and search words with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsa_in_if #(
  parameter int DATA_WIDTH = rsa_pkg::DATA_WIDTH_DEF
);
  import rsa_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [INDEX_W-1:0]           entry_index;
  logic signed [DATA_WIDTH-1:0] entry_value;
  logic signed [DATA_WIDTH-1:0] key;

  modport source (output valid, output action, output entry_index,
                  output entry_value, output key, input ready);
  modport sink   (input valid, input action, input entry_index,
                  input entry_value, input key, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rsa_out_if.sv =====
// ----------------------------------------------------------------------------
// rsa_out_if: result word channel
// Carries found flag and position with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsa_out_if;
  import rsa_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rsa_mem.sv =====
// ----------------------------------------------------------------------------
// rsa_mem: array storage
// Single port RAM, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_mem #(
  parameter int DEPTH      = rsa_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rsa_pkg::DATA_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                addr,
  input  wire logic signed [DATA_WIDTH-1:0] wdata,
  output logic signed [DATA_WIDTH-1:0]      rdata
);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rotated_array_search.sv =====
// ----------------------------------------------------------------------------
// rotated_array_search: search in a rotated ascending array
// Loads an array word by word and looks up keys with two halving searches.
// ----------------------------------------------------------------------------
// Usage:
//   din carries words: action 0 writes entry_value at entry_index (ignored
//   at or above DEPTH) and returns nothing; action 1 searches for key.
//   dout returns one word per search: found and position (0 when not found).
//   cfg_we/cfg_wdata set array_length (0 reads as 1, above DEPTH as DEPTH);
//   write it only while the block is idle.
// Operation:
//   A load writes the RAM straight from the accepted word. A search makes
//   one RAM read per probe through the single port, first the pivot search
//   against entry 0, then the key search.
//   din.ready is high only between searches.
// Reset: rst (synchronous) idles the sequencer, drops dout.valid and sets
//   array_length to 1. Array contents are not cleared.
// Stall: a finished result sits in the output register; the next search
//   may run meanwhile and waits at its end until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_array_search #(
  parameter int DEPTH      = rsa_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rsa_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [rsa_pkg::LEN_W-1:0] cfg_wdata,
  rsa_in_if.sink                       din,
  rsa_out_if.source                    dout
);
  import rsa_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW + 2 > LEN_W + 1) ? AW + 2 : LEN_W + 1;
  localparam logic signed [CW-1:0] DEPTH_X = CW'(DEPTH);
  localparam logic signed [CW-1:0] ONE_X   = CW'(1);

  state_t state, state_next;

  logic [LEN_W-1:0]             array_length;
  logic signed [CW-1:0]         nreg, lo, hi, mid, pivot;
  logic signed [DATA_WIDTH-1:0] kreg, elem0, pv;
  logic                         found_r;
  logic                         out_valid, out_found;
  logic [POS_W-1:0]             out_position;

  logic                         mem_we;
  logic [AW-1:0]                mem_addr;
  logic signed [DATA_WIDTH-1:0] rdata;

  logic signed [CW-1:0]         len_x, n_c, idx_x, nm1, lo_c, hi_c, mid_c;
  logic                         p_more, b_more, hit_c, load_ok, out_free, accept;

  rsa_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (din.entry_value),
    .rdata (rdata)
  );

  assign accept   = din.valid && din.ready;
  assign out_free = !out_valid || dout.ready;
  assign len_x    = $signed(CW'(array_length));
  assign idx_x    = $signed(CW'(din.entry_index));
  assign load_ok  = idx_x < DEPTH_X;
  assign nm1      = nreg - ONE_X;
  assign n_c      = (len_x == '0) ? ONE_X : ((len_x > DEPTH_X) ? DEPTH_X : len_x);

  // shared bound update and midpoint unit
  always_comb begin
    lo_c  = lo;
    hi_c  = hi;
    hit_c = 1'b0;
    case (state)
      S_W0: begin
        lo_c = '0;
        hi_c = nm1;
      end
      S_PCMP: begin
        if (rdata >= elem0) begin
          lo_c = mid + ONE_X;
        end else begin
          hi_c = mid;
        end
      end
      S_LVAL: begin
        if (kreg >= pv && kreg <= rdata) begin
          lo_c = pivot;
          hi_c = nm1;
        end else begin
          lo_c = '0;
          hi_c = pivot;
        end
      end
      S_BCMP: begin
        hit_c = (rdata == kreg);
        if (kreg > rdata) begin
          lo_c = mid + ONE_X;
        end else begin
          hi_c = mid - ONE_X;
        end
      end
      default: ;
    endcase
    p_more = lo_c < hi_c;
    b_more = lo_c <= hi_c;
    mid_c  = lo_c + ((hi_c - lo_c) >>> 1);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && din.action == ACT_SEARCH) begin
          state_next = S_W0;
        end
      end
      S_W0, S_PCMP: state_next = p_more ? S_PCMP : S_PVAL;
      S_PVAL:       state_next = S_LVAL;
      S_LVAL:       state_next = b_more ? S_BCMP : S_DONE;
      S_BCMP:       state_next = (!hit_c && b_more) ? S_BCMP : S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    din.ready = (state == S_IDLE);
    mem_we    = 1'b0;
    mem_addr  = mid_c[AW-1:0];
    case (state)
      S_IDLE: begin
        mem_we   = accept && din.action == ACT_LOAD && load_ok;
        mem_addr = (din.action == ACT_LOAD) ? AW'(din.entry_index) : '0;
      end
      S_W0, S_PCMP: mem_addr = p_more ? mid_c[AW-1:0] : lo_c[AW-1:0];
      S_PVAL:       mem_addr = nm1[AW-1:0];
      default:      mem_addr = mid_c[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      array_length <= LEN_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        array_length <= cfg_wdata;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kreg <= din.key;
        nreg <= n_c;
      end
      S_W0, S_PCMP: begin
        if (state == S_W0) begin
          elem0 <= rdata;
        end
        lo    <= lo_c;
        hi    <= hi_c;
        mid   <= mid_c;
        pivot <= lo_c;
      end
      S_PVAL: pv <= rdata;
      S_LVAL, S_BCMP: begin
        lo      <= lo_c;
        hi      <= hi_c;
        found_r <= hit_c;
        // on a hit mid keeps the matching index
        if (!hit_c) begin
          mid <= mid_c;
        end
      end
      default: ;
    endcase
    if (state == S_DONE && out_free) begin
      out_found    <= found_r;
      out_position <= found_r ? POS_W'($unsigned(mid)) : '0;
    end
  end

  assign dout.valid    = out_valid;
  assign dout.found    = out_found;
  assign dout.position = out_position;

  a_pivot_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_PCMP |-> (lo <= mid && mid < hi && hi < nreg))
    else $error("pivot probe outside its range");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_BCMP |-> (lo <= mid && mid <= hi && lo >= 0 && hi < nreg))
    else $error("key probe outside its range");

  a_pivot_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PVAL |-> (pivot >= 0 && pivot < nreg))
    else $error("pivot beyond array length");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    state == S_W0 |-> (nreg >= ONE_X && nreg <= DEPTH_X))
    else $error("search length not clamped");

endmodule

`default_nettype wire
